[sv/eatrm_pkg.sv]
// Shared types, constants and helper functions for the Euler angle to rotation matrix block.
package eatrm_pkg;

  // Iteration count of the sine/cosine unit, limited by the arctangent table.
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int N_ITER        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // Datapath widths.
  localparam int ANG_W = 16;
  localparam int RED_W = 17;
  localparam int XY_W  = 34;
  localparam int Z_W   = 32;
  localparam int Q14_W = 16;
  localparam int PR_W  = 32;
  localparam int SUM_W = 45;
  localparam int SAT_W = 48;

  // Latencies: reduction, iterations and rounding, then pair products,
  // triple products with sums, and the output register.
  localparam int CORDIC_LAT = N_ITER + 2;
  localparam int TOTAL_LAT  = CORDIC_LAT + 3;

  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic signed [Q14_W-1:0] q14_t;

  // Angle constants in 1/128 degree.
  localparam logic signed [RED_W-1:0] ANG_FULL    = 17'sd46080;
  localparam logic signed [RED_W-1:0] ANG_HALF    = 17'sd23040;
  localparam logic signed [RED_W-1:0] ANG_QUARTER = 17'sd11520;

  // Start value of x: inverse of the iteration gain in Q2.30.
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;
  localparam logic signed [XY_W-1:0] XY_HALF   = 34'sd32768;
  localparam logic signed [SUM_W-1:0] SUM_HALF = 45'sd134217728;
  localparam int Q14_ONE = 16384;

  // Arctangent of 2^-i in degrees times 2^23, rounded to nearest.
  localparam logic signed [Z_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
    32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
    32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
    32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
    32'sd7334,      32'sd3667,      32'sd1833,      32'sd917,
    32'sd458,       32'sd229,       32'sd115,       32'sd57
  };

  // Clamp a value to the closed range of plus or minus one in Q14.
  function automatic q14_t sat_q14(input logic signed [SAT_W-1:0] v);
    q14_t r;
    if (v > SAT_W'(Q14_ONE)) begin
      r = Q14_W'(Q14_ONE);
    end else if (v < -SAT_W'(Q14_ONE)) begin
      r = -Q14_W'(Q14_ONE);
    end else begin
      r = v[Q14_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/euler_angles_to_rotation_matrix_core.sv]
// Top level: yaw, pitch and roll in, Z-Y-X rotation matrix in Q1.14 out.
//
// Usage: each input item carries yaw_angle, pitch_angle and roll_angle in
// 1/128 degree, two's complement. Each item yields one result item with the
// nine entries m00..m22 of Rz(yaw)*Ry(pitch)*Rx(roll) in Q1.14.
// Both channels use valid/stall; an item moves on a clock edge with valid
// high and stall low.
// The pipeline has one reduction stage, one stage per CORDIC iteration,
// one rounding stage, then pair products, triple products with sums, and
// the output register. Throughput is one item per cycle unless the
// receiver stalls; every stage holds its own item.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears all valid bits; data registers are
// not reset. No state is kept between items.
module euler_angles_to_rotation_matrix_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  eatrm_pkg::angle_t in_yaw_angle,
  input  eatrm_pkg::angle_t in_pitch_angle,
  input  eatrm_pkg::angle_t in_roll_angle,
  output logic              out_valid,
  input  logic              out_stall,
  output eatrm_pkg::q14_t   out_m00,
  output eatrm_pkg::q14_t   out_m01,
  output eatrm_pkg::q14_t   out_m02,
  output eatrm_pkg::q14_t   out_m10,
  output eatrm_pkg::q14_t   out_m11,
  output eatrm_pkg::q14_t   out_m12,
  output eatrm_pkg::q14_t   out_m20,
  output eatrm_pkg::q14_t   out_m21,
  output eatrm_pkg::q14_t   out_m22
);
  import eatrm_pkg::*;

  logic                 ce;
  logic [TOTAL_LAT-1:0] vld_r;
  logic [TOTAL_LAT-1:0] vld_nxt;

  q14_t sy, cy, sp, cp, sr, cr;

  // Pair products and delayed factors.
  logic signed [PR_W-1:0] cycp_r, sycp_r, spsr_r, spcr_r, sycr_r, sysr_r;
  logic signed [PR_W-1:0] cycr_r, cysr_r, cpsr_r, cpcr_r;
  q14_t sy1_r, cy1_r, sp1_r;

  // Entries in Q42.
  logic signed [SUM_W-1:0] e_r [0:8];
  logic signed [SUM_W-1:0] e_nxt [0:8];
  q14_t m_r [0:8];

  // The pipeline advances unless a finished result is held by the receiver.
  assign ce       = !(vld_r[TOTAL_LAT-1] && out_stall);
  assign in_stall = !ce;

  always_comb begin
    vld_nxt = {vld_r[TOTAL_LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= vld_nxt;
    end
  end

  // Sine and cosine of the three angles.
  eatrm_cordic u_yaw (
    .clk(clk), .ce(ce), .angle(in_yaw_angle), .sin_q14(sy), .cos_q14(cy)
  );
  eatrm_cordic u_pitch (
    .clk(clk), .ce(ce), .angle(in_pitch_angle), .sin_q14(sp), .cos_q14(cp)
  );
  eatrm_cordic u_roll (
    .clk(clk), .ce(ce), .angle(in_roll_angle), .sin_q14(sr), .cos_q14(cr)
  );

  // Two-factor products in Q28.
  always_ff @(posedge clk) begin
    if (ce) begin
      cycp_r <= cy * cp;
      sycp_r <= sy * cp;
      spsr_r <= sp * sr;
      spcr_r <= sp * cr;
      sycr_r <= sy * cr;
      sysr_r <= sy * sr;
      cycr_r <= cy * cr;
      cysr_r <= cy * sr;
      cpsr_r <= cp * sr;
      cpcr_r <= cp * cr;
      sy1_r  <= sy;
      cy1_r  <= cy;
      sp1_r  <= sp;
    end
  end

  // Three-factor products and sums, all exact in Q42.
  always_comb begin
    e_nxt[0] = SUM_W'(cycp_r) <<< 14;
    e_nxt[1] = SUM_W'(cy1_r) * SUM_W'(spsr_r) - (SUM_W'(sycr_r) <<< 14);
    e_nxt[2] = SUM_W'(cy1_r) * SUM_W'(spcr_r) + (SUM_W'(sysr_r) <<< 14);
    e_nxt[3] = SUM_W'(sycp_r) <<< 14;
    e_nxt[4] = SUM_W'(sy1_r) * SUM_W'(spsr_r) + (SUM_W'(cycr_r) <<< 14);
    e_nxt[5] = SUM_W'(sy1_r) * SUM_W'(spcr_r) - (SUM_W'(cysr_r) <<< 14);
    e_nxt[6] = -(SUM_W'(sp1_r) <<< 28);
    e_nxt[7] = SUM_W'(cpsr_r) <<< 14;
    e_nxt[8] = SUM_W'(cpcr_r) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_r <= e_nxt;
    end
  end

  // Round Q42 to Q14, clamp, and hold in the output register.
  for (genvar k = 0; k < 9; k++) begin : g_out
    always_ff @(posedge clk) begin
      if (ce) begin
        m_r[k] <= sat_q14(SAT_W'((e_r[k] + SUM_HALF) >>> 28));
      end
    end
  end

  assign out_valid = vld_r[TOTAL_LAT-1];
  assign out_m00   = m_r[0];
  assign out_m01   = m_r[1];
  assign out_m02   = m_r[2];
  assign out_m10   = m_r[3];
  assign out_m11   = m_r[4];
  assign out_m12   = m_r[5];
  assign out_m20   = m_r[6];
  assign out_m21   = m_r[7];
  assign out_m22   = m_r[8];

endmodule

[sv/eatrm_cordic.sv]
// Pipelined sine and cosine of one angle: range reduction, CORDIC iterations, rounding.
module eatrm_cordic (
  input  logic            clk,
  input  logic            ce,
  input  eatrm_pkg::angle_t angle,
  output eatrm_pkg::q14_t sin_q14,
  output eatrm_pkg::q14_t cos_q14
);
  import eatrm_pkg::*;

  logic signed [RED_W-1:0] a_ext;
  logic signed [RED_W-1:0] a_wrap;
  logic signed [RED_W-1:0] a_red;
  logic                    neg_nxt;
  logic signed [Z_W-1:0]   z_nxt;

  logic signed [XY_W-1:0] x_r [0:N_ITER];
  logic signed [XY_W-1:0] y_r [0:N_ITER];
  logic signed [Z_W-1:0]  z_r [0:N_ITER];
  logic                   neg_r [0:N_ITER];

  logic signed [XY_W-1:0] x_rnd;
  logic signed [XY_W-1:0] y_rnd;
  q14_t                   cos_nxt;
  q14_t                   sin_nxt;
  q14_t                   sin_r;
  q14_t                   cos_r;

  // Fold the angle into one turn, then into the right half plane.
  always_comb begin
    a_ext   = RED_W'(angle);
    a_wrap  = a_ext;
    a_red   = a_ext;
    neg_nxt = 1'b0;
    if (a_ext >= ANG_HALF) begin
      a_wrap = a_ext - ANG_FULL;
    end else if (a_ext < -ANG_HALF) begin
      a_wrap = a_ext + ANG_FULL;
    end
    a_red = a_wrap;
    if (a_wrap > ANG_QUARTER) begin
      a_red   = ANG_HALF - a_wrap;
      neg_nxt = 1'b1;
    end else if (a_wrap < -ANG_QUARTER) begin
      a_red   = -ANG_HALF - a_wrap;
      neg_nxt = 1'b1;
    end
    z_nxt = {a_red[15:0], 16'b0};
  end

  // Entry stage of the iteration pipeline.
  always_ff @(posedge clk) begin
    if (ce) begin
      x_r[0]   <= CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= z_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  // One rotation step per stage; the shift amount is fixed per stage.
  for (genvar i = 0; i < N_ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (ce) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TAB[i];
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // Round Q30 to Q14, clamp, and restore the sign of the cosine.
  always_comb begin
    x_rnd   = (x_r[N_ITER] + XY_HALF) >>> 16;
    y_rnd   = (y_r[N_ITER] + XY_HALF) >>> 16;
    cos_nxt = sat_q14(SAT_W'(x_rnd));
    sin_nxt = sat_q14(SAT_W'(y_rnd));
    if (neg_r[N_ITER]) begin
      cos_nxt = -cos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q14 = sin_r;
  assign cos_q14 = cos_r;

endmodule

[tb/tb_euler_angles_to_rotation_matrix_core.sv]
// Testbench for the yaw/pitch/roll to rotation matrix core, self-checking against a local predictor.
`timescale 1ns / 100ps

module tb_euler_angles_to_rotation_matrix_core;
  import eatrm_pkg::*;

  // Angle constants in 1/128 degree.
  localparam longint FULL_TURN    = 46080;
  localparam longint HALF_TURN    = 23040;
  localparam longint QUARTER_TURN = 11520;
  localparam longint UNIT_Q14     = 16384;

  typedef struct {
    q14_t m [9];
  } matrix_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  angle_t  in_yaw_angle = '0;
  angle_t  in_pitch_angle = '0;
  angle_t  in_roll_angle = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  q14_t    out_m [9];

  matrix_t pending_matrices [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      matrices_checked = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  euler_angles_to_rotation_matrix_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_yaw_angle  (in_yaw_angle),
    .in_pitch_angle(in_pitch_angle),
    .in_roll_angle (in_roll_angle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_m00       (out_m[0]),
    .out_m01       (out_m[1]),
    .out_m02       (out_m[2]),
    .out_m10       (out_m[3]),
    .out_m11       (out_m[4]),
    .out_m12       (out_m[5]),
    .out_m20       (out_m[6]),
    .out_m21       (out_m[7]),
    .out_m22       (out_m[8])
  );

  always #5 clk = ~clk;

  // Clamp to plus or minus one in Q14.
  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q14) begin
      return UNIT_Q14;
    end
    if (v < -UNIT_Q14) begin
      return -UNIT_Q14;
    end
    return v;
  endfunction

  // Sine and cosine in Q14 of an angle, by quadrant reduction and CORDIC.
  function automatic void angle_sin_cos(input angle_t ang, output longint s,
                                        output longint c);
    longint a;
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip_cos;
    a = longint'(ang);
    flip_cos = 1'b0;
    x = 64'sh26DD3B6A;
    y = 0;
    if (a >= HALF_TURN) a -= FULL_TURN;
    if (a < -HALF_TURN) a += FULL_TURN;
    if (a > QUARTER_TURN) begin
      a = HALF_TURN - a;
      flip_cos = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a = -HALF_TURN - a;
      flip_cos = 1'b1;
    end
    z = a * 65536;
    for (int i = 0; i < N_ITER; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    c = clamp_unit((x + 32768) >>> 16);
    s = clamp_unit((y + 32768) >>> 16);
    if (flip_cos) c = -c;
  endfunction

  // Round a Q42 product to Q14 with saturation.
  function automatic q14_t round_q42(input longint v);
    return q14_t'(clamp_unit((v + (64'sd1 <<< 27)) >>> 28));
  endfunction

  // Rotation matrix Rz(yaw) * Ry(pitch) * Rx(roll).
  function automatic matrix_t rotation_of(input angle_t yaw, input angle_t pitch,
                                          input angle_t roll);
    matrix_t r;
    longint sy, cy, sp, cp, sr, cr;
    angle_sin_cos(yaw, sy, cy);
    angle_sin_cos(pitch, sp, cp);
    angle_sin_cos(roll, sr, cr);
    r.m[0] = round_q42(cy * cp * UNIT_Q14);
    r.m[1] = round_q42(cy * sp * sr - sy * cr * UNIT_Q14);
    r.m[2] = round_q42(cy * sp * cr + sy * sr * UNIT_Q14);
    r.m[3] = round_q42(sy * cp * UNIT_Q14);
    r.m[4] = round_q42(sy * sp * sr + cy * cr * UNIT_Q14);
    r.m[5] = round_q42(sy * sp * cr - cy * sr * UNIT_Q14);
    r.m[6] = round_q42(-sp * UNIT_Q14 * UNIT_Q14);
    r.m[7] = round_q42(cp * sr * UNIT_Q14);
    r.m[8] = round_q42(cp * cr * UNIT_Q14);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Send one item, idling at random first; in_valid stays high for the next one.
  task automatic send_angles(input angle_t yaw, input angle_t pitch, input angle_t roll);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_yaw_angle   <= yaw;
    in_pitch_angle <= pitch;
    in_roll_angle  <= roll;
    do @(posedge clk); while (in_stall);
    pending_matrices.push_back(rotation_of(yaw, pitch, roll));
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    matrix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matrices.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (out_m[i] !== want.m[i]) begin
            report_mismatch($sformatf("entry m%0d%0d got %0d expected %0d",
                                      i / 3, i % 3, out_m[i], want.m[i]));
          end
        end
        matrices_checked++;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Extreme angles, turn wrap and quadrant borders on every axis.
  task automatic test_directed_angles();
    angle_t corners [14] = '{16'sd0, 16'sd11520, -16'sd11520, 16'sd11521, -16'sd11521,
                             16'sd23039, 16'sd23040, -16'sd23040, -16'sd23041,
                             16'sd32767, -16'sd32768, 16'sd5760, -16'sd17280, 16'sd1};
    foreach (corners[i]) begin
      send_angles(corners[i], corners[(i + 5) % 14], corners[(i + 9) % 14]);
    end
    send_angles(16'sd32767, 16'sd32767, 16'sd32767);
    send_angles(-16'sd32768, -16'sd32768, -16'sd32768);
    send_angles(16'sd0, 16'sd11520, 16'sd0);
    send_angles(16'sd0, -16'sd11520, 16'sd0);
  endtask

  // Random angles: mostly the full range, some near the quadrant borders.
  task automatic test_random_angles(input int count, input int idle_pct,
                                    input int stall_pct);
    angle_t a [3];
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      foreach (a[k]) begin
        if ($urandom_range(3) == 0) begin
          a[k] = angle_t'(int'(QUARTER_TURN) * $urandom_range(4) - 23040
                          + $urandom_range(8) - 4);
        end else begin
          a[k] = angle_t'($urandom);
        end
      end
      send_angles(a[0], a[1], a[2]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_angles();
    pause_until_drained();
    test_random_angles(200, 0, 0);
    test_random_angles(200, 82, 0);
    test_random_angles(200, 0, 82);
    pause_until_drained();
    test_random_angles(200, 7, 7);
    in_valid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 5) @(posedge clk);
    $display("Sent %0d angle items, checked %0d matrices, %0d mismatches.",
             items_sent, matrices_checked, mismatch_count);
    $display("Covered borders, wrap, extremes and four idle/stall mixes.");
    if (mismatch_count == 0 && pending_matrices.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding.", pending_matrices.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
sv/eatrm_pkg.sv
sv/eatrm_cordic.sv
sv/euler_angles_to_rotation_matrix_core.sv
tb/tb_euler_angles_to_rotation_matrix_core.sv
